// File: rtl/first_fit_block_allocator_assert.svh
// Assertion macros for the first-fit block allocator.
// Included by the datapath, which checks its own logic; no other dependencies.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication
`define FFBA_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("first_fit_block_allocator: assertion failed");
// Next-cycle implication
`define FFBA_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("first_fit_block_allocator: assertion failed");
`else
`define FFBA_ASSERT_IMP(name, clk, rst_n, ante, cons)
`define FFBA_ASSERT_NXT(name, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/ffba_pkg.sv
// Shared types and constants for the first-fit block allocator.
// No dependencies; used by the controller, the datapath and the top level.
package ffba_pkg;

    localparam int FFBA_MAX_BLOCKS = 64;
    localparam int FFBA_HEADER_BYTES = 16;
    localparam logic [31:0] FFBA_HEAP_LIMIT_RST = 32'h0001_0000;

    typedef enum logic [0:0] {
        FN_ALLOC   = 1'b0,
        FN_RELEASE = 1'b1
    } t_ffba_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ZERO    = 2'd1,
        ST_NOSPACE = 2'd2,
        ST_UNKNOWN = 2'd3
    } t_ffba_status;

    typedef struct packed {
        t_ffba_func  func;
        logic [31:0] req_size;
        logic [31:0] block_addr;
    } t_ffba_req;

    typedef struct packed {
        logic [31:0]  result_addr;
        t_ffba_status status;
    } t_ffba_rsp;

    // One row of the block table
    typedef struct packed {
        logic [31:0] offset;
        logic [31:0] size;
        logic        free;
    } t_ffba_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } t_ffba_state;

    // Controller to datapath
    typedef struct packed {
        logic capture;
        logic scan;
        logic commit;
        logic out_load;
    } t_ffba_cmd;

    // Datapath to controller
    typedef struct packed {
        logic trivial;
        logic hit;
        logic scan_done;
        logic out_busy;
    } t_ffba_stat;

endpackage

// File: rtl/ffba_ctrl.sv
// Controller state machine of the first-fit block allocator.
// Depends on ffba_pkg; drives the datapath through t_ffba_cmd.
module ffba_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  ffba_pkg::t_ffba_stat i_stat,
    output logic                o_in_ready,
    output ffba_pkg::t_ffba_cmd  o_cmd
);

    ffba_pkg::t_ffba_state r_state;
    ffba_pkg::t_ffba_state n_state;

    // Advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ffba_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = ffba_pkg::S_SCAN;
                end
            end
            ffba_pkg::S_SCAN: begin
                if (i_stat.trivial || i_stat.hit || i_stat.scan_done) begin
                    n_state = ffba_pkg::S_FINISH;
                end
            end
            ffba_pkg::S_FINISH: begin
                if (!i_stat.out_busy) begin
                    n_state = ffba_pkg::S_IDLE;
                end
            end
            default: n_state = ffba_pkg::S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ffba_pkg::S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            ffba_pkg::S_SCAN: begin
                if (i_stat.trivial || i_stat.hit || i_stat.scan_done) begin
                    o_cmd.commit = 1'b1;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            ffba_pkg::S_FINISH: begin
                o_cmd.out_load = !i_stat.out_busy;
            end
            default: o_cmd = '0;
        endcase
    end

endmodule

// File: rtl/ffba_datapath.sv
// Datapath of the first-fit block allocator: block table memory, scan
// pipeline, heap break, block count and result registers. Depends on ffba_pkg.
`include "first_fit_block_allocator_assert.svh"
module ffba_datapath #(
    parameter int MAX_BLOCKS   = ffba_pkg::FFBA_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffba_pkg::FFBA_HEADER_BYTES
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  ffba_pkg::t_ffba_req  i_in,
    input  logic                 i_cfg_we,
    input  logic [31:0]          i_cfg_wdata,
    input  logic                 i_out_ready,
    input  ffba_pkg::t_ffba_cmd  i_cmd,
    output ffba_pkg::t_ffba_stat o_stat,
    output logic                 o_out_valid,
    output ffba_pkg::t_ffba_rsp  o_out
);

    localparam int AW = $clog2(MAX_BLOCKS);
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
    localparam logic [31:0] HDR = 32'(HEADER_BYTES);

    // Block table
    ffba_pkg::t_ffba_entry r_mem [MAX_BLOCKS];
    ffba_pkg::t_ffba_entry r_rd_data;

    // Request and scan state
    ffba_pkg::t_ffba_req r_req;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_cmp_idx;
    logic                r_pend;
    logic                w_re;

    // Allocator state
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [31:0]   r_break;
    logic [31:0]   n_break;
    logic [31:0]   r_limit;

    // Result and output registers
    ffba_pkg::t_ffba_rsp r_res;
    ffba_pkg::t_ffba_rsp n_res;
    ffba_pkg::t_ffba_rsp r_out;
    logic                r_out_valid;

    // Table write port
    logic                  w_we;
    logic [AW-1:0]         w_waddr;
    ffba_pkg::t_ffba_entry w_wdata;
    logic                  w_append;

    // Compare and capacity checks
    logic        w_is_alloc;
    logic        w_alloc_match;
    logic        w_rel_match;
    logic        w_hit;
    logic        w_last;
    logic        w_full;
    logic        w_fits;
    logic [33:0] w_end;

    assign w_is_alloc    = (r_req.func == ffba_pkg::FN_ALLOC);
    assign w_alloc_match = r_rd_data.free && (r_rd_data.size >= r_req.req_size);
    assign w_rel_match   = ({1'b0, r_rd_data.offset} + {1'b0, HDR})
                           == {1'b0, r_req.block_addr};
    assign w_hit         = r_pend && (w_is_alloc ? w_alloc_match : w_rel_match);
    assign w_last        = ((r_cmp_idx + CW'(1)) == r_count);
    assign w_full        = (r_count >= MAXC);
    assign w_end         = {2'b00, r_break} + {2'b00, HDR} + {2'b00, r_req.req_size};
    assign w_fits        = (w_end <= {2'b00, r_limit});
    assign w_re          = i_cmd.scan && (r_idx < r_count);

    assign o_stat.trivial   = w_is_alloc ? (r_req.req_size == 32'd0)
                                         : (r_req.block_addr == 32'd0);
    assign o_stat.hit       = w_hit;
    assign o_stat.scan_done = !r_pend && (r_idx >= r_count);
    assign o_stat.out_busy  = r_out_valid && !i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Table memory: one write, one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
        end
    end

    // Decide the outcome of the request and the table update
    always_comb begin
        w_we     = 1'b0;
        w_waddr  = r_cmp_idx[AW-1:0];
        w_wdata  = r_rd_data;
        w_append = 1'b0;
        n_count  = r_count;
        n_break  = r_break;
        n_res.result_addr = 32'd0;
        n_res.status      = ffba_pkg::ST_OK;
        if (i_cmd.commit) begin
            priority if (o_stat.trivial) begin
                n_res.status = w_is_alloc ? ffba_pkg::ST_ZERO : ffba_pkg::ST_OK;
            end else if (w_hit && w_is_alloc) begin
                w_we              = 1'b1;
                w_wdata.free      = 1'b0;
                n_res.result_addr = r_rd_data.offset + HDR;
            end else if (w_hit) begin
                if (w_last) begin
                    n_break = r_rd_data.offset;
                    n_count = r_count - CW'(1);
                end else begin
                    w_we         = 1'b1;
                    w_wdata.free = 1'b1;
                end
            end else if (w_is_alloc) begin
                if (w_full || !w_fits) begin
                    n_res.status = ffba_pkg::ST_NOSPACE;
                end else begin
                    w_append          = 1'b1;
                    w_we              = 1'b1;
                    w_waddr           = r_count[AW-1:0];
                    w_wdata.offset    = r_break;
                    w_wdata.size      = r_req.req_size;
                    w_wdata.free      = 1'b0;
                    n_count           = r_count + CW'(1);
                    n_break           = w_end[31:0];
                    n_res.result_addr = r_break + HDR;
                end
            end else begin
                n_res.status = ffba_pkg::ST_UNKNOWN;
            end
        end
    end

    // Hold request and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_in;
        end
        if (i_cmd.scan) begin
            r_cmp_idx <= r_idx;
        end
        if (i_cmd.commit) begin
            r_res <= n_res;
        end
        if (i_cmd.out_load) begin
            r_out <= r_res;
        end
    end

    // Control state: scan pointer, table count, break, limit, output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_count     <= '0;
            r_break     <= 32'd0;
            r_limit     <= ffba_pkg::FFBA_HEAP_LIMIT_RST;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_idx  <= '0;
                r_pend <= 1'b0;
            end else if (i_cmd.scan) begin
                r_pend <= w_re;
                if (w_re) begin
                    r_idx <= r_idx + CW'(1);
                end
            end
            r_count <= n_count;
            r_break <= n_break;
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    `FFBA_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= MAXC)
    `FFBA_ASSERT_IMP(a_hit_in_table, i_clk, i_rst_n, i_cmd.commit && w_hit, r_cmp_idx < r_count)
    `FFBA_ASSERT_NXT(a_append_grows, i_clk, i_rst_n, w_append,
                     r_count == $past(r_count) + CW'(1))

endmodule

// File: rtl/first_fit_block_allocator.sv
// A zero-size allocation or null release finishes without a scan; otherwise the
// block table is scanned from entry 0 until the first match or the end of the
// table, and the result is then loaded into the output register.
// Throughput: one request at a time; an untaken result in the output register
// holds the next result and stalls the input.
// Reset (synchronous, active low) empties the table, zeroes the break and sets
// the heap limit to 65536; the table memory itself is not cleared.
module first_fit_block_allocator #(
    parameter int MAX_BLOCKS   = ffba_pkg::FFBA_MAX_BLOCKS,
    parameter int HEADER_BYTES = ffba_pkg::FFBA_HEADER_BYTES
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ffba_pkg::t_ffba_req i_in,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ffba_pkg::t_ffba_rsp o_out,
    input  logic                i_cfg_we,
    input  logic [31:0]         i_cfg_wdata
);

    ffba_pkg::t_ffba_cmd  w_cmd;
    ffba_pkg::t_ffba_stat w_stat;

    // Sequence the request
    ffba_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (w_stat),
        .o_in_ready (o_in_ready),
        .o_cmd      (w_cmd)
    );

    // Table, scan and result
    ffba_datapath #(
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_out_ready (i_out_ready),
        .i_cmd       (w_cmd),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out       (o_out)
    );

endmodule
